[hw/rtl/xcfr_pkg.sv]
// Shared types and constants for the XOR-checked frame receiver.
package xcfr_pkg;

  // Frame layout
  localparam logic [15:0] FrameMagic     = 16'hA4B0;
  localparam logic [15:0] LengthOverhead = 16'd3;
  localparam logic [2:0]  HeaderBytes    = 3'd6;
  localparam logic [2:0]  HeaderLast     = 3'd5;

  // Body buffer size; a body must satisfy body + 1 <= BodyBufferBytes
  localparam int unsigned BodyBufferBytes = 512;
  localparam logic [16:0] BodyLimit       = 17'(BodyBufferBytes);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SUM   = 2'd1,
    ST_LARGE = 2'd2,
    ST_MAGIC = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] command;
    logic [15:0] body_length;
    status_t     status;
  } result_t;

endpackage

[hw/rtl/xcfr_in_stage.sv]
// Input register stage: holds one received byte until the frame engine takes it.
module xcfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

[hw/rtl/xcfr_frame_engine.sv]
// Frame engine: header parse, body pass-through, XOR check and status.
module xcfr_frame_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_check_magic,
  input  logic             item_valid,
  input  logic [7:0]       item_byte,
  input  logic             take,
  output logic             has_result,
  output xcfr_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_CHECK  = 2'd2
  } phase_t;

  phase_t      phase_r,   phase_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [15:0] magic_r,   magic_nxt;
  logic [15:0] length_r,  length_nxt;
  logic [15:0] command_r, command_nxt;
  logic [15:0] left_r,    left_nxt;
  logic [7:0]  xor_r,     xor_nxt;
  logic        check_magic_r;

  logic [2:0]        hidx;
  logic [7:0]        xor_base;
  logic [15:0]       body_len;
  logic [7:0]        res_data;
  logic              res_end;
  xcfr_pkg::status_t res_status;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    magic_nxt   = magic_r;
    length_nxt  = length_r;
    command_nxt = command_r;
    left_nxt    = left_r;
    xor_nxt     = xor_r;
    hidx        = 3'd0;
    xor_base    = 8'd0;
    has_result  = 1'b0;
    res_data    = 8'd0;
    res_end     = 1'b0;
    res_status  = xcfr_pkg::ST_OK;

    case (phase_r)
      PH_BODY: begin
        xor_nxt  = xor_r ^ item_byte;
        left_nxt = left_r - 16'd1;
        if (left_nxt == 16'd0) begin
          phase_nxt = PH_CHECK;
        end
        has_result = 1'b1;
        res_data   = item_byte;
      end
      PH_CHECK: begin
        has_result = 1'b1;
        res_end    = 1'b1;
        if (xor_r != item_byte) begin
          res_status = xcfr_pkg::ST_SUM;
        end else if (check_magic_r && (magic_r != xcfr_pkg::FrameMagic)) begin
          res_status = xcfr_pkg::ST_MAGIC;
        end
        phase_nxt   = PH_HEADER;
        hdr_idx_nxt = 3'd0;
        left_nxt    = 16'd0;
        xor_nxt     = 8'd0;
      end
      default: begin
        phase_nxt = PH_HEADER;
        hidx      = (hdr_idx_r >= xcfr_pkg::HeaderBytes) ? 3'd0 : hdr_idx_r;
        xor_base  = (hidx == 3'd0) ? 8'd0 : xor_r;
        xor_nxt   = xor_base ^ item_byte;
        case (hidx)
          3'd0:    magic_nxt   = {item_byte, 8'd0};
          3'd1:    magic_nxt   = {magic_r[15:8], item_byte};
          3'd2:    length_nxt  = {item_byte, 8'd0};
          3'd3:    length_nxt  = {length_r[15:8], item_byte};
          3'd4:    command_nxt = {item_byte, 8'd0};
          default: command_nxt = {command_r[15:8], item_byte};
        endcase
        if (hidx < xcfr_pkg::HeaderLast) begin
          hdr_idx_nxt = hidx + 3'd1;
        end else begin
          hdr_idx_nxt = 3'd0;
          if ((length_nxt < xcfr_pkg::LengthOverhead) ||
              ({1'b0, length_nxt - xcfr_pkg::LengthOverhead} >= xcfr_pkg::BodyLimit)) begin
            has_result = 1'b1;
            res_end    = 1'b1;
            res_status = xcfr_pkg::ST_LARGE;
            left_nxt   = 16'd0;
            xor_nxt    = 8'd0;
          end else begin
            left_nxt  = length_nxt - xcfr_pkg::LengthOverhead;
            phase_nxt = (left_nxt == 16'd0) ? PH_CHECK : PH_BODY;
          end
        end
      end
    endcase
  end

  assign body_len           = length_nxt - xcfr_pkg::LengthOverhead;
  assign result.data_byte   = res_data;
  assign result.frame_end   = res_end;
  assign result.command     = command_nxt;
  assign result.body_length = body_len;
  assign result.status      = res_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      hdr_idx_r     <= 3'd0;
      magic_r       <= 16'd0;
      length_r      <= 16'd0;
      command_r     <= 16'd0;
      left_r        <= 16'd0;
      xor_r         <= 8'd0;
      check_magic_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        check_magic_r <= cfg_check_magic;
      end
      if (item_valid && take) begin
        phase_r   <= phase_nxt;
        hdr_idx_r <= hdr_idx_nxt;
        magic_r   <= magic_nxt;
        length_r  <= length_nxt;
        command_r <= command_nxt;
        left_r    <= left_nxt;
        xor_r     <= xor_nxt;
      end
    end
  end

endmodule

[hw/rtl/xcfr_out_reg.sv]
// Result register: holds one result item until the receiver takes it.
module xcfr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  xcfr_pkg::result_t load_data,
  output logic              out_valid,
  input  logic              out_ready,
  output xcfr_pkg::result_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  xcfr_pkg::result_t data_r;

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

[hw/rtl/xor_checked_frame_receiver_unit.sv]
// Top level of the XOR-checked frame receiver.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received serial byte per
// item. Frames are magic(2) length(2) command(2) body checksum(1), fields
// big-endian; length counts the body plus three.
// Result channel (out_valid/out_ready/out_*): one item per body byte
// (frame_end low, status ok), and one closing item per frame carrying the
// command, body length and status (ok, checksum mismatch, body too large,
// bad magic). Header bytes other than the last give no item.
// cfg_we/cfg_check_magic: writes the magic-check enable; write while idle.
// Timing: an accepted byte is held in the input register; the frame engine
// then updates its state and loads the result register in the same cycle,
// so each result passes through the input register and the result register.
// Throughput is one byte per cycle while out_ready is high; the engine's state
// update is the only loop.
// Stalls: the result register holds its item while out_ready is low; the
// input register still takes a byte, and in_ready drops only when both
// registers hold items and the held byte produces a result.
// Reset (rst_n low, synchronous): both registers empty, engine hunting for
// a header, checksum and header fields zero, magic check disabled.
module xor_checked_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_check_magic,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_frame_end,
  output logic [15:0] out_command,
  output logic [15:0] out_body_length,
  output logic [1:0]  out_status
);

  logic              item_valid;
  logic [7:0]        item_byte;
  logic              advance;
  logic              take;
  logic              has_result;
  logic              out_can_load;
  logic              out_load;
  xcfr_pkg::result_t eng_result;
  xcfr_pkg::result_t out_data;

  // Result register can take a new item when empty or draining this cycle.
  assign out_can_load = !out_valid || out_ready;
  // Held byte moves on if it makes no result or the result has a place.
  assign advance      = !has_result || out_can_load;
  assign take         = item_valid && advance;
  assign out_load     = item_valid && has_result && out_can_load;

  xcfr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  xcfr_frame_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_check_magic (cfg_check_magic),
    .item_valid      (item_valid),
    .item_byte       (item_byte),
    .take            (take),
    .has_result      (has_result),
    .result          (eng_result)
  );

  xcfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_data (eng_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_data_byte   = out_data.data_byte;
  assign out_frame_end   = out_data.frame_end;
  assign out_command     = out_data.command;
  assign out_body_length = out_data.body_length;
  assign out_status      = out_data.status;

`ifndef NO_ASSERTIONS
  // Input side stalls only when the result side is blocked.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result register could drain");

  // Body byte items always carry ok status.
  a_body_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |-> (out_status == xcfr_pkg::ST_OK))
    else $error("body byte item with non-ok status");

  // Closing items carry a zero data byte.
  a_end_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_data_byte == 8'd0))
    else $error("closing item with nonzero data byte");

  // A result is loaded only when the engine holds a byte and takes it.
  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (item_valid && take))
    else $error("result loaded without the engine taking a byte");
`endif

endmodule
